>>> rtl/core/ssbi_pkg.sv
// types and constants for the swept segment box test
// no dependencies
package ssbi_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int QUOT_BITS     = FRACTION_BITS + 2;
   localparam int PARAM_BITS    = FRACTION_BITS + 3;
   localparam int DIV_LATENCY   = FRACTION_BITS + 3;
   localparam int NUM_BITS      = 36;
   localparam int DEN_BITS      = 33;
   localparam int REM_BITS      = 35;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] box_center_x;
      logic signed [31:0] box_center_y;
      logic signed [31:0] box_center_z;
      logic [30:0]        half_extent_x;
      logic [30:0]        half_extent_y;
      logic [30:0]        half_extent_z;
   } req_word_type;

   typedef struct packed {
      logic                     hit;
      logic [FRACTION_BITS:0]   hit_t;
   } rsp_word_type;

endpackage

>>> rtl/core/ssbi_slab_div.sv
// pipelined restoring divider for one slab face parameter, saturated
// depends on ssbi_pkg
module ssbi_slab_div
   import ssbi_pkg::*;
(
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [NUM_BITS-1:0]   num,
   input  logic [DEN_BITS-1:0]          den,
   output logic signed [PARAM_BITS-1:0] param
);

   localparam int NSTEP = QUOT_BITS;

   logic [REM_BITS-1:0]  rem_ff [0:NSTEP];
   logic [REM_BITS-1:0]  dv_ff  [0:NSTEP];
   logic [QUOT_BITS-1:0] q_ff   [0:NSTEP];
   logic                 neg_ff [0:NSTEP];
   logic                 ovf_ff [0:NSTEP];
   logic [REM_BITS-1:0]  dv_in;

   assign dv_in = {den, 2'b00};

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num[REM_BITS-1:0];
         dv_ff[0]  <= dv_in;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NUM_BITS-1];
         ovf_ff[0] <= !num[NUM_BITS-1] && (num[REM_BITS-1:0] >= dv_in);
      end
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      logic [REM_BITS:0] sh_in;
      logic              bit_in;
      assign sh_in  = {rem_ff[k], 1'b0};
      assign bit_in = sh_in >= {1'b0, dv_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= bit_in ? REM_BITS'(sh_in - {1'b0, dv_ff[k]})
                                  : sh_in[REM_BITS-1:0];
            dv_ff[k+1]  <= dv_ff[k];
            q_ff[k+1]   <= {q_ff[k][QUOT_BITS-2:0], bit_in};
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   localparam logic signed [PARAM_BITS-1:0] ParamMax =
      PARAM_BITS'((1 << FRACTION_BITS) + 1);

   always_comb begin
      if (neg_ff[NSTEP]) begin
         param = '1;
      end else if (ovf_ff[NSTEP] || ($signed({1'b0, q_ff[NSTEP]}) > ParamMax)) begin
         param = ParamMax;
      end else begin
         param = $signed({1'b0, q_ff[NSTEP]});
      end
   end

endmodule

>>> rtl/core/swept_segment_box_intersect.sv
// swept segment versus grown box slab test, top level
// depends on ssbi_pkg and ssbi_slab_div
//
// channel  | ports            | dir
// req      | req_valid/ready  | in   query word
// rsp      | rsp_valid/ready  | out  hit word
// csr      | csr_wr_en/data   | in   sweep radius
//
// one word per cycle while the response is not held; FRACTION_BITS is 16 (Q16.16);
// most of the pipeline is the six pipelined dividers, one quotient bit per stage.
// synchronous reset clears valid bits and the radius register.
// a held response freezes the whole pipeline; req_ready follows that stall.
module swept_segment_box_intersect
   import ssbi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [30:0]  csr_wr_data
);

   localparam logic signed [PARAM_BITS-1:0] One = PARAM_BITS'(1 << FRACTION_BITS);

   logic en;
   logic [30:0] radius_ff;

   logic               v1_ff;
   logic signed [31:0] s1_ff [0:2];
   logic signed [31:0] c1_ff [0:2];
   logic [31:0]        ext1_ff [0:2];
   logic signed [32:0] d1_ff [0:2];

   logic               v2_ff;
   logic signed [31:0] s2_ff [0:2];
   logic signed [33:0] lo2_ff [0:2];
   logic signed [33:0] hi2_ff [0:2];
   logic [32:0]        ad2_ff [0:2];
   logic               dn2_ff [0:2];
   logic               dz2_ff [0:2];

   logic                      v3_ff;
   logic signed [NUM_BITS-1:0] nn3_ff [0:2];
   logic signed [NUM_BITS-1:0] nf3_ff [0:2];
   logic [DEN_BITS-1:0]        den3_ff [0:2];
   logic                       dz3_ff [0:2];
   logic                       in3_ff [0:2];

   logic       dlv_ff [0:DIV_LATENCY-1];
   logic [2:0] dlz_ff [0:DIV_LATENCY-1];
   logic [2:0] dli_ff [0:DIV_LATENCY-1];

   logic signed [PARAM_BITS-1:0] tn [0:2];
   logic signed [PARAM_BITS-1:0] tf [0:2];

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   logic signed [31:0] in_s [0:2];
   logic signed [31:0] in_e [0:2];
   logic signed [31:0] in_c [0:2];
   logic [30:0]        in_h [0:2];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign in_s[0] = req_word.start_x;
   assign in_s[1] = req_word.start_y;
   assign in_s[2] = req_word.start_z;
   assign in_e[0] = req_word.end_x;
   assign in_e[1] = req_word.end_y;
   assign in_e[2] = req_word.end_z;
   assign in_c[0] = req_word.box_center_x;
   assign in_c[1] = req_word.box_center_y;
   assign in_c[2] = req_word.box_center_z;
   assign in_h[0] = req_word.half_extent_x;
   assign in_h[1] = req_word.half_extent_y;
   assign in_h[2] = req_word.half_extent_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIV_LATENCY; i++) begin
            dlv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         dlv_ff[0]    <= v3_ff;
         for (int i = 1; i < DIV_LATENCY; i++) begin
            dlv_ff[i] <= dlv_ff[i-1];
         end
         rsp_valid_ff <= dlv_ff[DIV_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            // grow box, segment delta
            s1_ff[a]   <= in_s[a];
            c1_ff[a]   <= in_c[a];
            ext1_ff[a] <= {1'b0, in_h[a]} + {1'b0, radius_ff};
            d1_ff[a]   <= {in_e[a][31], in_e[a]} - {in_s[a][31], in_s[a]};
            // slab bounds, magnitude of delta
            s2_ff[a]   <= s1_ff[a];
            lo2_ff[a]  <= {{2{c1_ff[a][31]}}, c1_ff[a]} - {2'b00, ext1_ff[a]};
            hi2_ff[a]  <= {{2{c1_ff[a][31]}}, c1_ff[a]} + {2'b00, ext1_ff[a]};
            ad2_ff[a]  <= d1_ff[a][32] ? 33'(~d1_ff[a] + 33'd1) : d1_ff[a];
            dn2_ff[a]  <= d1_ff[a][32];
            dz2_ff[a]  <= (d1_ff[a] == '0);
            // face numerators, near/far swapped for negative delta
            nn3_ff[a]  <= dn2_ff[a]
               ? {{4{s2_ff[a][31]}}, s2_ff[a]} - {{2{hi2_ff[a][33]}}, hi2_ff[a]}
               : {{2{lo2_ff[a][33]}}, lo2_ff[a]} - {{4{s2_ff[a][31]}}, s2_ff[a]};
            nf3_ff[a]  <= dn2_ff[a]
               ? {{4{s2_ff[a][31]}}, s2_ff[a]} - {{2{lo2_ff[a][33]}}, lo2_ff[a]}
               : {{2{hi2_ff[a][33]}}, hi2_ff[a]} - {{4{s2_ff[a][31]}}, s2_ff[a]};
            den3_ff[a] <= ad2_ff[a];
            dz3_ff[a]  <= dz2_ff[a];
            in3_ff[a]  <= ($signed({{2{s2_ff[a][31]}}, s2_ff[a]}) >= lo2_ff[a])
                       && ($signed({{2{s2_ff[a][31]}}, s2_ff[a]}) <= hi2_ff[a]);
         end
         dlz_ff[0] <= {dz3_ff[2], dz3_ff[1], dz3_ff[0]};
         dli_ff[0] <= {in3_ff[2], in3_ff[1], in3_ff[0]};
         for (int i = 1; i < DIV_LATENCY; i++) begin
            dlz_ff[i] <= dlz_ff[i-1];
            dli_ff[i] <= dli_ff[i-1];
         end
         rsp_word_ff <= rsp_word_in;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      ssbi_slab_div u_near (
         .clock (clock),
         .en    (en),
         .num   (nn3_ff[a]),
         .den   (den3_ff[a]),
         .param (tn[a])
      );
      ssbi_slab_div u_far (
         .clock (clock),
         .en    (en),
         .num   (nf3_ff[a]),
         .den   (den3_ff[a]),
         .param (tf[a])
      );
   end

   always_comb begin
      logic signed [PARAM_BITS-1:0] tmin;
      logic signed [PARAM_BITS-1:0] tmax;
      logic                         fail;
      tmin = '0;
      tmax = One;
      fail = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (dlz_ff[DIV_LATENCY-1][a]) begin
            if (!dli_ff[DIV_LATENCY-1][a]) begin
               fail = 1'b1;
            end
         end else begin
            if (tn[a] > tmin) begin
               tmin = tn[a];
            end
            if (tf[a] < tmax) begin
               tmax = tf[a];
            end
         end
      end
      if (fail || (tmin > tmax)) begin
         rsp_word_in.hit   = 1'b0;
         rsp_word_in.hit_t = '0;
      end else begin
         rsp_word_in.hit   = 1'b1;
         rsp_word_in.hit_t = tmin[FRACTION_BITS:0];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("pipeline advanced under a held response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.hit_t == '0)
      else $error("miss carries a nonzero entry parameter");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.hit_t <= (FRACTION_BITS+1)'(1 << FRACTION_BITS))
      else $error("entry parameter above one");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

>>> test/tb_top.sv
// testbench for swept_segment_box_intersect: directed and random slab queries
// depends on ssbi_pkg and the block's rtl; predicts each hit word and checks it in order
`timescale 1ns / 1ps

module tb_top;
   import ssbi_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   logic         csr_wr_en;
   logic [30:0]  csr_wr_data;

   logic [30:0]  radius;
   rsp_word_type hit_queue[$];
   bit           failed;
   int unsigned  cycle_count;
   bit           hold_off;

   localparam int LATENCY = 4 + FRACTION_BITS + 3;
   localparam int unsigned CYCLE_LIMIT = 400000;

   swept_segment_box_intersect DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic longint face_param(longint num, longint den);
      longint n;
      longint q;
      n = num * (longint'(1) <<< FRACTION_BITS);
      q = n / den;
      if ((n % den) != 0 && n < 0) q = q - 1;
      if (q < -1) q = -1;
      if (q > (longint'(1) <<< FRACTION_BITS) + 1) q = (longint'(1) <<< FRACTION_BITS) + 1;
      return q;
   endfunction

   function automatic rsp_word_type predict_hit(req_word_type w);
      longint s[3], e[3], c[3], h[3];
      longint tmin, tmax, lo, hi, d, tn, tf;
      bit ok;
      rsp_word_type r;
      s = '{longint'(w.start_x), longint'(w.start_y), longint'(w.start_z)};
      e = '{longint'(w.end_x), longint'(w.end_y), longint'(w.end_z)};
      c = '{longint'(w.box_center_x), longint'(w.box_center_y), longint'(w.box_center_z)};
      h = '{longint'(w.half_extent_x), longint'(w.half_extent_y), longint'(w.half_extent_z)};
      tmin = 0;
      tmax = longint'(1) <<< FRACTION_BITS;
      ok = 1;
      for (int a = 0; a < 3 && ok; a++) begin
         lo = c[a] - (h[a] + longint'(radius));
         hi = c[a] + (h[a] + longint'(radius));
         d = e[a] - s[a];
         if (d == 0) begin
            ok = (s[a] >= lo) && (s[a] <= hi);
         end else begin
            if (d > 0) begin
               tn = face_param(lo - s[a], d);
               tf = face_param(hi - s[a], d);
            end else begin
               tn = face_param(s[a] - hi, -d);
               tf = face_param(s[a] - lo, -d);
            end
            if (tn > tmin) tmin = tn;
            if (tf < tmax) tmax = tf;
            ok = tmin <= tmax;
         end
      end
      r.hit = ok;
      r.hit_t = ok ? tmin[FRACTION_BITS:0] : '0;
      return r;
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $error("unexpected hit word %p", rsp_word);
               failed = 1;
            end else begin
               exp_word = hit_queue.pop_front();
               if (rsp_word.hit !== exp_word.hit) begin
                  $error("hit expected %0d actual %0d", exp_word.hit, rsp_word.hit);
                  failed = 1;
               end
               if (rsp_word.hit_t !== exp_word.hit_t) begin
                  $error("hit_t expected %0d actual %0d", exp_word.hit_t, rsp_word.hit_t);
                  failed = 1;
               end
            end
         end
      end
   end

   int unsigned rsp_stall_pct;
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_word(req_word_type w, int unsigned gap_pct);
      int unsigned gap;
      if ($urandom_range(99) < gap_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      hit_queue.push_back(predict_hit(w));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_all();
      req_valid <= 0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_radius(logic [30:0] value);
      drain_all();
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      radius = value;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom;
         default: return $signed($urandom_range(20 << 16, 0)) - (10 <<< 16);
      endcase
   endfunction

   function automatic logic [30:0] rand_half();
      case ($urandom_range(4))
         0: return 31'h7fff_ffff;
         1: return '0;
         2: return 31'($urandom);
         default: return 31'($urandom_range(4 << 16, 0));
      endcase
   endfunction

   function automatic req_word_type rand_query();
      req_word_type w;
      w.start_x = rand_coord();
      w.start_y = rand_coord();
      w.start_z = rand_coord();
      w.end_x = ($urandom_range(5) == 0) ? w.start_x : rand_coord();
      w.end_y = ($urandom_range(5) == 0) ? w.start_y : rand_coord();
      w.end_z = ($urandom_range(5) == 0) ? w.start_z : rand_coord();
      w.box_center_x = rand_coord();
      w.box_center_y = rand_coord();
      w.box_center_z = rand_coord();
      w.half_extent_x = rand_half();
      w.half_extent_y = rand_half();
      w.half_extent_z = rand_half();
      return w;
   endfunction

   function automatic req_word_type make_query(longint sx, longint sy, longint sz,
      longint ex, longint ey, longint ez, longint half);
      req_word_type w;
      w.start_x = 32'(sx); w.start_y = 32'(sy); w.start_z = 32'(sz);
      w.end_x = 32'(ex); w.end_y = 32'(ey); w.end_z = 32'(ez);
      w.box_center_x = '0; w.box_center_y = '0; w.box_center_z = '0;
      w.half_extent_x = 31'(half); w.half_extent_y = 31'(half); w.half_extent_z = 31'(half);
      return w;
   endfunction

   task automatic test_directed();
      longint one;
      req_word_type w;
      one = 64'sd65536;
      rsp_stall_pct = 0;
      send_word(make_query(-2*one, 0, 0, 2*one, 0, 0, one), 0);       // cross x
      send_word(make_query(-2*one, 0, 0, 2*one, 0, 0, 0), 0);         // zero-size box
      send_word(make_query(0, 0, 0, 0, 0, 0, 0), 0);                  // point on box
      send_word(make_query(one, 0, 0, one, 0, 0, one), 0);            // zero delta, on bound
      send_word(make_query(one + 1, 0, 0, one + 1, 0, 0, one), 0);    // zero delta, outside
      send_word(make_query(2*one, 2*one, 0, -2*one, -2*one, 0, one), 0); // negative delta
      send_word(make_query(5*one, 0, 0, 3*one, 0, 0, one), 0);        // misses before box
      send_word(make_query(-one, 0, 0, 2*one, 5*one, 0, one), 0);     // starts on the x face
      send_word(make_query(-3*one, 0, 0, -one, 0, 0, one), 0);        // end touches face
      send_word(make_query(0, 0, 0, 1, 1, 1, one), 0);                // tiny delta
      send_word(make_query(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
         64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'h7fff_ffff), 0);
      send_word(make_query(64'sd2147483647, 0, 0, -64'sd2147483648, 0, 0, 0), 0);
      w = make_query(-64'sd2147483648, 0, 0, -64'sd2147483648, 0, 0, 64'h7fff_ffff);
      w.box_center_x = 32'sh7fff_ffff;
      send_word(w, 0);
      w = make_query(0, 0, 0, one, one, one, one);
      w.box_center_x = 32'sh8000_0000; w.box_center_y = 32'sh7fff_ffff;
      send_word(w, 0);
      w.start_x = 32'hffff_ffff; w.start_y = 32'hffff_ffff; w.start_z = 32'hffff_ffff;
      w.end_x = 32'hffff_ffff; w.end_y = 32'hffff_ffff; w.end_z = 32'hffff_ffff;
      w.half_extent_x = '1; w.half_extent_y = '1; w.half_extent_z = '1;
      send_word(w, 0);
      drain_all();
   endtask

   task automatic test_random(int unsigned count, int unsigned gap_pct, int unsigned stall_pct);
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_word(rand_query(), gap_pct);
      drain_all();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_back_pressure();
      rsp_stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (3 * LATENCY) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 60; i++) send_word(rand_query(), 0);
      join
      drain_all();
   endtask

   initial begin
      req_valid = 0;
      req_word = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      rsp_stall_pct = 0;
      hold_off = 0;
      failed = 0;
      cycle_count = 0;
      radius = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(120, 30, 30);
      write_radius(31'h7fff_ffff);
      test_directed();
      test_random(60, 10, 10);
      write_radius(31'h0000_8000);
      test_random(150, 0, 0);
      test_back_pressure();
      write_radius(31'($urandom));
      test_random(120, 50, 50);
      write_radius('0);
      test_random(100, 20, 20);
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> swept_segment_box_intersect.f
rtl/core/ssbi_pkg.sv
rtl/core/ssbi_slab_div.sv
rtl/core/swept_segment_box_intersect.sv
test/tb_top.sv
